// ===== rtl/power_meter_phase_calc_unit_defines.svh =====
// assertion macros used by the power meter phase calculation sequencer rtl
`ifndef POWER_METER_PHASE_CALC_UNIT_DEFINES_SVH
`define POWER_METER_PHASE_CALC_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define PMPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmpc assertion failed");

// next-cycle implication, checked on clk, off while rst_n is low
`define PMPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmpc assertion failed");

`endif

// ===== rtl/pmpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmpc_pkg;

    // divider geometry: 48 bit dividend, 16 bit divisor, two quotient bits per cycle
    localparam int DIVD_W    = 48;
    localparam int DIVS_W    = 16;
    localparam int DIV_STEPS = DIVD_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // square root geometry: 32 bit radicand, 16 bit root, one root bit per cycle
    localparam int RAD_W     = 32;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SCNT_W    = $clog2(ROOT_W);

    // operation codes of the sequence
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_VSCALE = 3'd0;
    localparam logic [OP_W-1:0] OP_VCAL   = 3'd1;
    localparam logic [OP_W-1:0] OP_SQRT   = 3'd2;
    localparam logic [OP_W-1:0] OP_PF     = 3'd3;
    localparam logic [OP_W-1:0] OP_CUR    = 3'd4;
    localparam logic [OP_W-1:0] OP_FREQ   = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST   = OP_FREQ;

    // register indexes
    localparam logic REG_CT_RATIO = 1'b0;
    localparam logic REG_FIXED_CT = 1'b1;

    // arithmetic constants
    localparam logic [15:0] VOLT_MUL  = 16'(600 * 64);
    localparam logic [15:0] VOLT_DIV  = 16'd730;
    localparam logic [15:0] CAL_BASE  = 16'd1000;
    localparam int          PF_SHIFT  = 10;
    localparam logic [13:0] CUR_MUL   = 14'd16000;
    localparam logic [14:0] FREQ_NUM  = 15'd27965;
    localparam logic [13:0] CT_LOW_LIM = 14'd61;
    localparam logic [13:0] CT_MID_LIM = 14'd201;
    localparam logic [15:0] THR_LOW   = 16'd8;
    localparam logic [15:0] THR_MID   = 16'd40;
    localparam logic [15:0] THR_HIGH  = 16'd80;
    localparam int          NUM_PHASES = 3;

    // controller to datapath commands
    typedef struct packed {
        logic            load_in;
        logic            op_start;
        logic [OP_W-1:0] op;
        logic            op_store;
        logic            load_out;
    } pmpc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic unit_busy;
        logic unit_done;
    } pmpc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pmpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmpc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pmpc_pkg::DIVD_W-1:0] dividend,
    input  wire logic [pmpc_pkg::DIVS_W-1:0] divisor,
    output logic                            busy,
    output logic                            done,
    output logic [pmpc_pkg::DIVD_W-1:0]     quotient
);
    import pmpc_pkg::*;

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVS_W:0] r1, r1m, r2, r2m;
    logic            ge1, ge2;

    // two restoring steps per cycle
    always_comb
    begin
        r1  = {rem_reg, quo_reg[DIVD_W-1]};
        ge1 = (r1 >= {1'b0, dsr_reg});
        r1m = ge1 ? (r1 - {1'b0, dsr_reg}) : r1;
        r2  = {r1m[DIVS_W-1:0], quo_reg[DIVD_W-2]};
        ge2 = (r2 >= {1'b0, dsr_reg});
        r2m = ge2 ? (r2 - {1'b0, dsr_reg}) : r2;
        rem_next = r2m[DIVS_W-1:0];
        quo_next = {quo_reg[DIVD_W-3:0], ge1, ge2};
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/pmpc_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmpc_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pmpc_pkg::RAD_W-1:0] radicand,
    output logic                            busy,
    output logic                            done,
    output logic [pmpc_pkg::ROOT_W-1:0]     root
);
    import pmpc_pkg::*;

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+2:0] r, trial, rm;
    logic              ge;

    // one root bit per cycle
    always_comb
    begin
        r     = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial = {1'b0, root_reg, 2'b01};
        ge    = (r >= trial);
        rm    = ge ? (r - trial) : r;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rm[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == SCNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/pmpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmpc_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pmpc_pkg::pmpc_cmd_t cmd,
    output pmpc_pkg::pmpc_sts_t      sts,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [13:0]         cfg_wdata,
    input  wire logic [1:0]          phase,
    input  wire logic [30:0]         voltage_sum,
    input  wire logic signed [10:0]  voltage_offset,
    input  wire logic signed [15:0]  active_sum,
    input  wire logic signed [15:0]  reactive_sum,
    input  wire logic [15:0]         period_count,
    output logic [1:0]               phase_out,
    output logic [15:0]              voltage,
    output logic [15:0]              apparent_power,
    output logic signed [11:0]       power_factor,
    output logic [15:0]              current,
    output logic                     low_current,
    output logic [7:0]               frequency,
    output logic                     divide_error
);
    import pmpc_pkg::*;

    // configuration
    logic [13:0] ct_ratio_reg;
    logic        fixed_ct_reg;

    // captured transaction
    logic [1:0]         phase_reg;
    logic [30:0]        vsum_reg;
    logic signed [10:0] off_reg;
    logic signed [15:0] p_reg;
    logic signed [15:0] q_reg;
    logic [7:0]         per_reg;

    // intermediate results
    logic [32:0]        vt_reg;
    logic [15:0]        volt_reg;
    logic [15:0]        s_reg;
    logic [11:0]        pf_reg;
    logic [15:0]        cur_reg;
    logic [7:0]         freq_reg;
    logic               err_reg;

    logic [15:0] last_cur_reg [NUM_PHASES];

    // output register
    logic [1:0]  phase_o_reg;
    logic [15:0] volt_o_reg;
    logic [15:0] s_o_reg;
    logic [11:0] pf_o_reg;
    logic [15:0] cur_o_reg;
    logic        low_o_reg;
    logic [7:0]  freq_o_reg;
    logic        err_o_reg;

    // unit interfaces
    logic [DIVD_W-1:0] div_dividend, div_quo;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_start, div_busy, div_done;
    logic [RAD_W-1:0]  radicand;
    logic [ROOT_W-1:0] root;
    logic              sqrt_start, sqrt_busy, sqrt_done;

    logic [42:0]        vmul;
    logic [11:0]        cal;
    logic [10:0]        cal_mag;
    logic [43:0]        vcal;
    logic signed [31:0] pp, qq;
    logic [16:0]        pabs;
    logic [29:0]        smul;
    logic [11:0]        pf_mag;
    logic [15:0]        thr;
    logic               low;

    // operand preparation
    always_comb
    begin
        vmul    = vsum_reg[30:4] * VOLT_MUL;
        cal     = CAL_BASE[11:0] + {off_reg[10], off_reg};
        cal_mag = cal[11] ? 11'd0 : cal[10:0];
        vcal    = vt_reg * cal_mag;
        pp      = p_reg * p_reg;
        qq      = q_reg * q_reg;
        radicand = RAD_W'(pp) + RAD_W'(qq);
        pabs    = p_reg[15] ? (17'd0 - {1'b1, p_reg}) : {1'b0, p_reg};
        smul    = s_reg * CUR_MUL;
        pf_mag  = div_quo[11:0];
    end

    // divider operand select
    always_comb
    begin
        div_dividend = '0;
        div_divisor  = '0;
        unique case (cmd.op)
            OP_VSCALE:
            begin
                div_dividend = DIVD_W'(vmul);
                div_divisor  = VOLT_DIV;
            end
            OP_VCAL:
            begin
                div_dividend = DIVD_W'(vcal);
                div_divisor  = CAL_BASE;
            end
            OP_PF:
            begin
                div_dividend = DIVD_W'({pabs, PF_SHIFT'(0)});
                div_divisor  = s_reg;
            end
            OP_CUR:
            begin
                div_dividend = DIVD_W'(smul);
                div_divisor  = volt_reg;
            end
            OP_FREQ:
            begin
                div_dividend = DIVD_W'(FREQ_NUM);
                div_divisor  = {8'd0, per_reg};
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    assign div_start  = cmd.op_start && (cmd.op != OP_SQRT);
    assign sqrt_start = cmd.op_start && (cmd.op == OP_SQRT);

    pmpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    pmpc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (root)
    );

    assign sts.unit_busy = div_busy | sqrt_busy;
    assign sts.unit_done = div_done | sqrt_done;

    // low-current threshold and flag
    always_comb
    begin
        if (fixed_ct_reg)
            thr = THR_HIGH;
        else if (ct_ratio_reg < CT_LOW_LIM)
            thr = THR_LOW;
        else if (ct_ratio_reg < CT_MID_LIM)
            thr = THR_MID;
        else
            thr = THR_HIGH;
        low = 1'b0;
        if (phase_reg != 2'd3)
            low = (last_cur_reg[phase_reg] < thr);
    end

    // capture, result store and output load
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            phase_reg <= phase;
            vsum_reg  <= voltage_sum;
            off_reg   <= voltage_offset;
            p_reg     <= active_sum;
            q_reg     <= reactive_sum;
            per_reg   <= period_count[7:0];
            err_reg   <= 1'b0;
        end
        else if (cmd.op_store)
        begin
            case (cmd.op)
                OP_VSCALE: vt_reg <= div_quo[32:0];
                OP_VCAL:   volt_reg <= (div_quo[DIVD_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
                OP_SQRT:   s_reg <= root;
                OP_PF:
                begin
                    if (s_reg == '0)
                    begin
                        pf_reg  <= '0;
                        err_reg <= 1'b1;
                    end
                    else
                        pf_reg <= p_reg[15] ? (12'd0 - pf_mag) : pf_mag;
                end
                OP_CUR:
                begin
                    if (volt_reg == '0)
                    begin
                        cur_reg <= '0;
                        err_reg <= 1'b1;
                    end
                    else
                        cur_reg <= (div_quo[DIVD_W-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
                end
                OP_FREQ:
                begin
                    if (per_reg == '0)
                    begin
                        freq_reg <= '0;
                        err_reg  <= 1'b1;
                    end
                    else
                        freq_reg <= (div_quo[DIVD_W-1:8] != '0) ? 8'hFF : div_quo[7:0];
                end
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            phase_o_reg <= phase_reg;
            volt_o_reg  <= volt_reg;
            s_o_reg     <= s_reg;
            pf_o_reg    <= pf_reg;
            cur_o_reg   <= cur_reg;
            low_o_reg   <= low;
            freq_o_reg  <= freq_reg;
            err_o_reg   <= err_reg;
        end
    end

    // configuration and per-phase history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_ratio_reg <= '0;
            fixed_ct_reg <= 1'b0;
            for (int i = 0; i < NUM_PHASES; i++)
                last_cur_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_CT_RATIO: ct_ratio_reg <= cfg_wdata;
                    REG_FIXED_CT: fixed_ct_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.load_out && (phase_reg != 2'd3))
                last_cur_reg[phase_reg] <= cur_reg;
        end
    end

    assign phase_out      = phase_o_reg;
    assign voltage        = volt_o_reg;
    assign apparent_power = s_o_reg;
    assign power_factor   = pf_o_reg;
    assign current        = cur_o_reg;
    assign low_current    = low_o_reg;
    assign frequency      = freq_o_reg;
    assign divide_error   = err_o_reg;

endmodule

`default_nettype wire

// ===== rtl/pmpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "power_meter_phase_calc_unit_defines.svh"

module pmpc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output pmpc_pkg::pmpc_cmd_t      cmd,
    input  wire pmpc_pkg::pmpc_sts_t sts
);
    import pmpc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic            out_valid_reg, out_valid_next;
    logic            load_out;

    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                    op_next    = OP_VSCALE;
                end
            end
            ST_START:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (sts.unit_done)
                begin
                    if (op_reg == OP_LAST)
                        state_next = ST_FINISH;
                    else
                    begin
                        state_next = ST_START;
                        op_next    = op_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output transaction slot
    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_VSCALE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cmd.load_in  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.op_start = (state_reg == ST_START);
    assign cmd.op       = op_reg;
    assign cmd.op_store = (state_reg == ST_WAIT) && sts.unit_done;
    assign cmd.load_out = load_out;

    `PMPC_ASSERT_NEXT(a_start_runs_unit, cmd.op_start, sts.unit_busy)
    `PMPC_ASSERT_SAME(a_finish_after_last, state_reg == ST_FINISH, op_reg == OP_LAST)
    `PMPC_ASSERT_SAME(a_out_from_finish, $rose(out_valid_reg), $past(state_reg) == ST_FINISH)

endmodule

`default_nettype wire

// ===== rtl/power_meter_phase_calc_unit.sv =====
// one transaction at a time: in_stall holds off input until the result is in the output register
// the arithmetic runs on the shared radix-4 divider
//   (24 steps, used five times) and the 16-step square root unit
// a finished result waits in the output register while the next transaction is taken
// reset: rst_n asynchronous active low clears the sequencer, config and phase history
`timescale 1ns / 1ps
`default_nettype none

module power_meter_phase_calc_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [13:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         phase,
    input  wire logic [30:0]        voltage_sum,
    input  wire logic signed [10:0] voltage_offset,
    input  wire logic signed [15:0] active_sum,
    input  wire logic signed [15:0] reactive_sum,
    input  wire logic [15:0]        period_count,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              phase_out,
    output logic [15:0]             voltage,
    output logic [15:0]             apparent_power,
    output logic signed [11:0]      power_factor,
    output logic [15:0]             current,
    output logic                    low_current,
    output logic [7:0]              frequency,
    output logic                    divide_error
);
    import pmpc_pkg::*;

    pmpc_cmd_t cmd;
    pmpc_sts_t sts;

    // sequencer
    pmpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic and state
    pmpc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .phase          (phase),
        .voltage_sum    (voltage_sum),
        .voltage_offset (voltage_offset),
        .active_sum     (active_sum),
        .reactive_sum   (reactive_sum),
        .period_count   (period_count),
        .phase_out      (phase_out),
        .voltage        (voltage),
        .apparent_power (apparent_power),
        .power_factor   (power_factor),
        .current        (current),
        .low_current    (low_current),
        .frequency      (frequency),
        .divide_error   (divide_error)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_power_meter_phase_calc_unit.sv =====
`timescale 1ns / 1ps

module tb_power_meter_phase_calc_unit;
    import pmpc_pkg::*;

    typedef struct packed {
        logic [1:0]         ph;
        logic [30:0]        vsum;
        logic signed [10:0] offs;
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic [15:0]        per;
    } meter_item_t;

    typedef struct packed {
        logic [1:0]  ph;
        logic [15:0] volt;
        logic [15:0] s;
        logic [11:0] pf;
        logic [15:0] cur;
        logic        low;
        logic [7:0]  freq;
        logic        err;
    } phase_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_addr;
    logic [13:0]        cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         phase;
    logic [30:0]        voltage_sum;
    logic signed [10:0] voltage_offset;
    logic signed [15:0] active_sum;
    logic signed [15:0] reactive_sum;
    logic [15:0]        period_count;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         phase_out;
    logic [15:0]        voltage;
    logic [15:0]        apparent_power;
    logic signed [11:0] power_factor;
    logic [15:0]        current;
    logic               low_current;
    logic [7:0]         frequency;
    logic               divide_error;

    // model copy of registers and per-phase current history
    logic [13:0]   ct_ratio_m;
    logic          fixed_ct_m;
    logic [15:0]   prev_current [NUM_PHASES];

    meter_item_t   pending_items [$];
    phase_result_t expected_results [$];
    int            mismatches;
    int            accepted_items;
    int            total_items;

    power_meter_phase_calc_unit dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // floor square root, one root bit at a time
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // expected metering result; updates the current history
    function automatic phase_result_t calc_phase_result(meter_item_t it);
        phase_result_t   r;
        longint          vt;
        longint          p;
        longint          q;
        longint          pf;
        longint unsigned volt;
        longint unsigned s;
        longint unsigned cur;
        longint unsigned per;
        longint unsigned freq;
        logic [15:0]     thr;
        r.err = 1'b0;
        if (fixed_ct_m)
            thr = THR_HIGH;
        else if (ct_ratio_m < CT_LOW_LIM)
            thr = THR_LOW;
        else if (ct_ratio_m < CT_MID_LIM)
            thr = THR_MID;
        else
            thr = THR_HIGH;

        // voltage scale and calibration
        vt = longint'(it.vsum >> 4);
        vt = vt * 38400 / 730;
        vt = vt * (1000 + longint'(it.offs)) / 1000;
        if (vt < 0)
            volt = 0;
        else if (vt > 65535)
            volt = 65535;
        else
            volt = longint'(vt);

        // apparent power
        p = longint'(it.p);
        q = longint'(it.q);
        s = floor_root(longint'(p * p + q * q));
        if (s > 65535)
            s = 65535;

        // power factor
        if (s == 0)
        begin
            pf = 0;
            r.err = 1'b1;
        end
        else
            pf = (p * 1024) / longint'(s);

        // current
        if (volt == 0)
        begin
            cur = 0;
            r.err = 1'b1;
        end
        else
        begin
            cur = (s * 16000) / volt;
            if (cur > 65535)
                cur = 65535;
        end

        // frequency
        per = it.per[7:0];
        if (per == 0)
        begin
            freq = 0;
            r.err = 1'b1;
        end
        else
        begin
            freq = 27965 / per;
            if (freq > 255)
                freq = 255;
        end

        r.low = 1'b0;
        if (it.ph < NUM_PHASES)
        begin
            r.low = prev_current[it.ph] < thr;
            prev_current[it.ph] = cur[15:0];
        end
        r.ph   = it.ph;
        r.volt = volt[15:0];
        r.s    = s[15:0];
        r.pf   = pf[11:0];
        r.cur  = cur[15:0];
        r.freq = freq[7:0];
        return r;
    endfunction

    // random item, a mix of realistic magnitudes and full-range noise
    function automatic meter_item_t rand_meter_item();
        meter_item_t it;
        it.ph = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        case ($urandom_range(3))
            0: it.vsum = 31'($urandom_range(30000));
            1: it.vsum = 31'($urandom_range(1500000));
            2: it.vsum = 31'($urandom_range(25000));
            default: it.vsum = 31'($urandom);
        endcase
        if ($urandom_range(7) == 0)
            it.offs = 11'($urandom);
        else
            it.offs = 11'(int'($urandom_range(1998)) - 999);
        case ($urandom_range(3))
            0: begin
                it.p = 16'(int'($urandom_range(20)) - 10);
                it.q = 16'(int'($urandom_range(20)) - 10);
            end
            1: begin
                it.p = 16'(int'($urandom_range(2000)) - 1000);
                it.q = 16'(int'($urandom_range(2000)) - 1000);
            end
            default: begin
                it.p = 16'($urandom);
                it.q = 16'($urandom);
            end
        endcase
        it.per = 16'($urandom);
        if ($urandom_range(15) == 0)
            it.per[7:0] = 8'd0;
        return it;
    endfunction

    // idle pattern follows progress through the run
    function automatic bit sender_idles();
        if (accepted_items < total_items / 3)
            return $urandom_range(99) < 29;
        else if (accepted_items < 2 * total_items / 3)
            return $urandom_range(99) < 46;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (accepted_items < total_items / 3)
            return $urandom_range(99) < 46;
        else if (accepted_items < 2 * total_items / 3)
            return $urandom_range(99) < 29;
        return 1'b0;
    endfunction

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(calc_phase_result(pending_items.pop_front()));
                accepted_items++;
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_items.size() > 0 && !sender_idles())
                begin
                    in_valid       <= 1'b1;
                    phase          <= pending_items[0].ph;
                    voltage_sum    <= pending_items[0].vsum;
                    voltage_offset <= pending_items[0].offs;
                    active_sum     <= pending_items[0].p;
                    reactive_sum   <= pending_items[0].q;
                    period_count   <= pending_items[0].per;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        phase_result_t got;
        phase_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{phase_out, voltage, apparent_power, power_factor, current,
                        low_current, frequency, divide_error};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            out_stall <= receiver_stalls();
        end
    end

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 14'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_CT_RATIO)
            ct_ratio_m = 14'(value);
        else
            fixed_ct_m = value[0];
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (160) @(posedge clk);
    endtask

    task automatic add_item(input logic [1:0] ph, input logic [30:0] vs, input int offs,
                            input int p, input int q, input logic [15:0] per);
        meter_item_t it;
        it = '{ph, vs, 11'(offs), 16'(p), 16'(q), per};
        pending_items.push_back(it);
    endtask

    // stimulus
    initial
    begin
        int ct_list [8];
        int fx_list [8];
        ct_list = '{0, 60, 61, 200, 201, 9999, 16383, 5};
        fx_list = '{0, 0, 0, 0, 0, 2, 3, 1};
        total_items = 1150;
        accepted_items = 0;
        mismatches = 0;
        ct_ratio_m = '0;
        fixed_ct_m = 1'b0;
        for (int i = 0; i < NUM_PHASES; i++)
            prev_current[i] = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_CT_RATIO;
        cfg_wdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        phase = '0;
        voltage_sum = '0;
        voltage_offset = '0;
        active_sum = '0;
        reactive_sum = '0;
        period_count = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int c = 0; c < 8; c++)
        begin
            wait_idle();
            write_reg(REG_CT_RATIO, ct_list[c]);
            write_reg(REG_FIXED_CT, fx_list[c]);
            @(negedge clk);
            if (c == 0)
            begin
                // field extremes and divide-by-zero corners
                add_item(2'd0, 31'd0, 0, 0, 0, 16'h0000);
                add_item(2'd1, 31'h7fffffff, 999, 32767, 32767, 16'hffff);
                add_item(2'd2, 31'h7fffffff, -1024, -32768, -32768, 16'h0001);
                add_item(2'd0, 31'd4200, -999, -32768, 0, 16'h5580);
                add_item(2'd1, 31'd4200, 1023, 0, -32768, 16'haa6d);
                add_item(2'd2, 31'd20000, -1001, 100, 50, 16'h0002);
                add_item(2'd3, 31'd20000, 0, 3, 4, 16'h00ff);
                add_item(2'd0, 31'd20000, 0, 1, 0, 16'h0100);
                add_item(2'd0, 31'd20000, 0, 0, 0, 16'h0037);
                add_item(2'd1, 31'd15, 0, 1000, 1000, 16'h0064);
                add_item(2'd2, 31'd16, -1000, -5, 5, 16'h0032);
                add_item(2'd3, 31'h55555555, 341, -21846, 21845, 16'h2a55);
                add_item(2'd1, 31'h2aaaaaaa, -342, 21845, -21846, 16'hd5aa);
                add_item(2'd2, 31'd3000000, 500, 7, -7, 16'h0070);
                add_item(2'd0, 31'd60000, 0, 30000, -20000, 16'h0003);
                add_item(2'd1, 31'd100, 10, 2, 1, 16'h0080);
            end
            for (int k = 0; k < total_items / 8; k++)
                pending_items.push_back(rand_meter_item());
        end

        wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("tb_power_meter_phase_calc_unit passed");
        else
            $display("tb_power_meter_phase_calc_unit failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("tb_power_meter_phase_calc_unit failed");
        $finish;
    end

endmodule
